// File: rtl/sfcs_pkg.sv
`timescale 1ns / 1ps

package sfcs_pkg;

    // Field widths of the stream words.
    localparam int ADDR_W = 24;
    localparam int LEN_W  = 25;
    localparam int OP_W   = 3;

    // Default geometry of the flash part (page and sector sizes are powers of two).
    localparam int PAGE_BYTES_DEF   = 256;
    localparam int SECTOR_BYTES_DEF = 65536;
    localparam int ADDR_BITS_DEF    = 24;

    // Results one input word can cause, and depth of the command queue.
    localparam int MAX_RES     = 8;
    localparam int IDX_W       = 3;
    localparam int QUEUE_DEPTH = 2;

    // Operation codes on the input side.
    localparam logic [OP_W-1:0] OP_READ   = 3'd0;
    localparam logic [OP_W-1:0] OP_WRITE  = 3'd1;
    localparam logic [OP_W-1:0] OP_WDATA  = 3'd2;
    localparam logic [OP_W-1:0] OP_ERASE  = 3'd3;
    localparam logic [OP_W-1:0] OP_STATUS = 3'd4;
    localparam logic [OP_W-1:0] OP_RDATA  = 3'd5;

    // Flash command bytes.
    localparam logic [7:0] CMD_RDSR = 8'h05;
    localparam logic [7:0] CMD_WREN = 8'h06;
    localparam logic [7:0] CMD_READ = 8'h03;
    localparam logic [7:0] CMD_PP   = 8'h02;
    localparam logic [7:0] CMD_SE   = 8'hD8;
    localparam logic [7:0] INV_MASK = 8'hFF;
    localparam logic [7:0] WIP_MASK = 8'h01;

    typedef enum logic [2:0] {
        K_TX   = 3'd0,
        K_RX   = 3'd1,
        K_HOST = 3'd2,
        K_DONE = 3'd3,
        K_REJ  = 3'd4,
        K_ERR  = 3'd5
    } t_kind;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'b0001,
        PH_POLL  = 4'b0010,
        PH_READ  = 4'b0100,
        PH_WRITE = 4'b1000
    } t_phase;

    typedef enum logic [1:0] {
        REQ_NONE  = 2'd0,
        REQ_READ  = 2'd1,
        REQ_WRITE = 2'd2,
        REQ_ERASE = 2'd3
    } t_req;

    // One SPI action or host result.
    typedef struct packed {
        t_kind      kind;
        logic [7:0] value;
        logic       fe;
    } t_res;

    // All results caused by one input word.
    typedef struct packed {
        t_res [MAX_RES-1:0] slots;
        logic [IDX_W-1:0]   last_idx;
    } t_batch;

    function automatic t_res mk_res(t_kind kind, logic [7:0] value, logic fe);
        t_res r;
        r.kind  = kind;
        r.value = value;
        r.fe    = fe;
        return r;
    endfunction

endpackage

// File: rtl/sfcs_front.sv
`timescale 1ns / 1ps

module sfcs_front
    import sfcs_pkg::*;
#(
    parameter int PAGE_BYTES   = PAGE_BYTES_DEF,
    parameter int SECTOR_BYTES = SECTOR_BYTES_DEF,
    parameter int ADDR_BITS    = ADDR_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_wdata,
    input  logic              i_take,
    input  logic [OP_W-1:0]   i_op,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [LEN_W-1:0]  i_len,
    input  logic [7:0]        i_data,
    output t_batch            o_batch
);

    localparam int PAGE_W = $clog2(PAGE_BYTES);
    localparam int SEC_W  = $clog2(SECTOR_BYTES);

    logic                 r_invert;
    t_phase               r_phase, n_phase;
    t_req                 r_req, n_req;
    logic [ADDR_BITS-1:0] r_addr, n_addr;
    logic [LEN_W-1:0]     r_rem, n_rem;

    t_res [MAX_RES-1:0]   v_slots;
    logic [IDX_W-1:0]     v_n;
    logic                 v_err;
    logic [ADDR_BITS-1:0] in_addr;
    logic [31:0]          in_addr_ext;
    logic [ADDR_W-1:0]    cur_addr24;
    logic [ADDR_BITS-1:0] addr_inc;
    logic [ADDR_BITS-1:0] addr_sec;
    logic [LEN_W-1:0]     rem_dec;
    logic [7:0]           dmask;
    logic                 misaligned;
    logic                 wr_fe;

    // Request address is taken modulo the address space.
    assign in_addr     = i_addr[ADDR_BITS-1:0];
    assign in_addr_ext = 32'(in_addr);
    assign cur_addr24  = ADDR_W'(r_addr);
    assign addr_inc    = ADDR_BITS'(32'(r_addr) + 32'd1);
    assign addr_sec    = ADDR_BITS'(32'(r_addr) + 32'(SECTOR_BYTES));
    assign rem_dec     = r_rem - LEN_W'(1);
    assign dmask       = r_invert ? INV_MASK : 8'h00;
    assign misaligned  = (in_addr_ext[SEC_W-1:0] != '0) || (i_len[SEC_W-1:0] != '0);
    assign wr_fe       = (rem_dec == '0) || (addr_inc[PAGE_W-1:0] == '0);

    // Classify the word, build its result list and the next state.
    always_comb begin
        v_slots = '0;
        v_n     = '0;
        v_err   = 1'b0;
        n_phase = r_phase;
        n_req   = r_req;
        n_addr  = r_addr;
        n_rem   = r_rem;
        case (i_op)
            OP_READ, OP_WRITE, OP_ERASE: begin
                if (r_phase != PH_IDLE) begin
                    v_err = 1'b1;
                end else if (i_op == OP_ERASE && misaligned) begin
                    v_slots[v_n] = mk_res(K_REJ, 8'h00, 1'b0);
                    v_n = v_n + 1'b1;
                end else if (i_op != OP_READ && i_len == '0) begin
                    v_slots[v_n] = mk_res(K_DONE, 8'h00, 1'b0);
                    v_n = v_n + 1'b1;
                end else begin
                    n_req  = (i_op == OP_READ) ? REQ_READ :
                             ((i_op == OP_WRITE) ? REQ_WRITE : REQ_ERASE);
                    n_addr = in_addr;
                    n_rem  = i_len;
                    v_slots[v_n] = mk_res(K_TX, CMD_RDSR, 1'b0);
                    v_n = v_n + 1'b1;
                    v_slots[v_n] = mk_res(K_RX, 8'h00, 1'b1);
                    v_n = v_n + 1'b1;
                    n_phase = PH_POLL;
                end
            end
            OP_WDATA: begin
                if (r_phase != PH_WRITE || r_rem == '0) begin
                    v_err = 1'b1;
                end else begin
                    n_addr = addr_inc;
                    n_rem  = rem_dec;
                    v_slots[v_n] = mk_res(K_TX, i_data ^ dmask, wr_fe);
                    v_n = v_n + 1'b1;
                    if (rem_dec == '0) begin
                        v_slots[v_n] = mk_res(K_DONE, 8'h00, 1'b0);
                        v_n = v_n + 1'b1;
                        n_phase = PH_IDLE;
                        n_req   = REQ_NONE;
                    end else if (wr_fe) begin
                        v_slots[v_n] = mk_res(K_TX, CMD_RDSR, 1'b0);
                        v_n = v_n + 1'b1;
                        v_slots[v_n] = mk_res(K_RX, 8'h00, 1'b1);
                        v_n = v_n + 1'b1;
                        n_phase = PH_POLL;
                    end
                end
            end
            OP_STATUS: begin
                if (r_phase != PH_POLL) begin
                    v_err = 1'b1;
                end else if ((i_data & WIP_MASK) != 8'h00) begin
                    // Still busy: poll again.
                    v_slots[v_n] = mk_res(K_TX, CMD_RDSR, 1'b0);
                    v_n = v_n + 1'b1;
                    v_slots[v_n] = mk_res(K_RX, 8'h00, 1'b1);
                    v_n = v_n + 1'b1;
                end else begin
                    case (r_req)
                        REQ_READ: begin
                            v_slots[v_n] = mk_res(K_TX, CMD_READ, 1'b0);
                            v_n = v_n + 1'b1;
                            v_slots[v_n] = mk_res(K_TX, cur_addr24[23:16], 1'b0);
                            v_n = v_n + 1'b1;
                            v_slots[v_n] = mk_res(K_TX, cur_addr24[15:8], 1'b0);
                            v_n = v_n + 1'b1;
                            v_slots[v_n] = mk_res(K_TX, cur_addr24[7:0], r_rem == '0);
                            v_n = v_n + 1'b1;
                            if (r_rem == '0) begin
                                v_slots[v_n] = mk_res(K_DONE, 8'h00, 1'b0);
                                v_n = v_n + 1'b1;
                                n_phase = PH_IDLE;
                                n_req   = REQ_NONE;
                            end else begin
                                v_slots[v_n] = mk_res(K_RX, 8'h00, r_rem == LEN_W'(1));
                                v_n = v_n + 1'b1;
                                n_phase = PH_READ;
                            end
                        end
                        REQ_WRITE: begin
                            v_slots[v_n] = mk_res(K_TX, CMD_WREN, 1'b1);
                            v_n = v_n + 1'b1;
                            v_slots[v_n] = mk_res(K_TX, CMD_PP, 1'b0);
                            v_n = v_n + 1'b1;
                            v_slots[v_n] = mk_res(K_TX, cur_addr24[23:16], 1'b0);
                            v_n = v_n + 1'b1;
                            v_slots[v_n] = mk_res(K_TX, cur_addr24[15:8], 1'b0);
                            v_n = v_n + 1'b1;
                            v_slots[v_n] = mk_res(K_TX, cur_addr24[7:0], 1'b0);
                            v_n = v_n + 1'b1;
                            n_phase = PH_WRITE;
                        end
                        REQ_ERASE: begin
                            v_slots[v_n] = mk_res(K_TX, CMD_WREN, 1'b1);
                            v_n = v_n + 1'b1;
                            v_slots[v_n] = mk_res(K_TX, CMD_SE, 1'b0);
                            v_n = v_n + 1'b1;
                            v_slots[v_n] = mk_res(K_TX, cur_addr24[23:16], 1'b0);
                            v_n = v_n + 1'b1;
                            v_slots[v_n] = mk_res(K_TX, cur_addr24[15:8], 1'b0);
                            v_n = v_n + 1'b1;
                            v_slots[v_n] = mk_res(K_TX, cur_addr24[7:0], 1'b1);
                            v_n = v_n + 1'b1;
                            n_addr = addr_sec;
                            n_rem  = r_rem - LEN_W'(SECTOR_BYTES);
                            if (n_rem == '0) begin
                                v_slots[v_n] = mk_res(K_DONE, 8'h00, 1'b0);
                                v_n = v_n + 1'b1;
                                n_phase = PH_IDLE;
                                n_req   = REQ_NONE;
                            end else begin
                                v_slots[v_n] = mk_res(K_TX, CMD_RDSR, 1'b0);
                                v_n = v_n + 1'b1;
                                v_slots[v_n] = mk_res(K_RX, 8'h00, 1'b1);
                                v_n = v_n + 1'b1;
                                n_phase = PH_POLL;
                            end
                        end
                        default: begin
                            v_slots[v_n] = mk_res(K_DONE, 8'h00, 1'b0);
                            v_n = v_n + 1'b1;
                            n_phase = PH_IDLE;
                            n_req   = REQ_NONE;
                        end
                    endcase
                end
            end
            OP_RDATA: begin
                if (r_phase != PH_READ || r_rem == '0) begin
                    v_err = 1'b1;
                end else begin
                    v_slots[v_n] = mk_res(K_HOST, i_data ^ dmask, 1'b0);
                    v_n = v_n + 1'b1;
                    n_addr = addr_inc;
                    n_rem  = rem_dec;
                    if (rem_dec == '0) begin
                        v_slots[v_n] = mk_res(K_DONE, 8'h00, 1'b0);
                        v_n = v_n + 1'b1;
                        n_phase = PH_IDLE;
                        n_req   = REQ_NONE;
                    end else begin
                        v_slots[v_n] = mk_res(K_RX, 8'h00, rem_dec == LEN_W'(1));
                        v_n = v_n + 1'b1;
                    end
                end
            end
            default: begin
                v_err = 1'b1;
            end
        endcase
        // A protocol error leaves the state as it was.
        if (v_err) begin
            n_phase = r_phase;
            n_req   = r_req;
            n_addr  = r_addr;
            n_rem   = r_rem;
            v_slots[v_n] = mk_res(K_ERR, 8'h00, 1'b0);
            v_n = v_n + 1'b1;
        end
        o_batch.slots    = v_slots;
        o_batch.last_idx = v_n - 1'b1;
    end

    // Sequencer state advances on every accepted word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_invert <= 1'b1;
            r_phase  <= PH_IDLE;
            r_req    <= REQ_NONE;
            r_addr   <= '0;
            r_rem    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_invert <= i_cfg_wdata;
            end
            if (i_take) begin
                r_phase <= n_phase;
                r_req   <= n_req;
                r_addr  <= n_addr;
                r_rem   <= n_rem;
            end
        end
    end

endmodule

// File: rtl/sfcs_queue.sv
`timescale 1ns / 1ps

module sfcs_queue
    import sfcs_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_batch i_data,
    output logic   o_full,
    input  logic   i_pop,
    output logic   o_valid,
    output t_batch o_head
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_batch          r_mem [DEPTH];
    logic [PW-1:0]   r_wr, r_rd;
    logic [CW-1:0]   r_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rd];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// File: rtl/sfcs_back.sv
`timescale 1ns / 1ps

module sfcs_back
    import sfcs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_head_valid,
    input  t_batch     i_head,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output t_res       o_res,
    output logic       o_last
);

    logic [IDX_W-1:0] r_idx;
    logic             r_valid;
    t_res             r_res;
    logic             r_last;
    logic             load;
    logic             at_last;

    assign load    = i_head_valid && (!r_valid || i_ready);
    assign at_last = (r_idx == i_head.last_idx);
    assign o_pop   = load && at_last;
    assign o_valid = r_valid;
    assign o_res   = r_res;
    assign o_last  = r_last;

    // Output register, refilled from the head batch one result a cycle while the receiver is ready.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= at_last ? '0 : r_idx + 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_res  <= i_head.slots[r_idx];
            r_last <= at_last;
        end
    end

endmodule

// File: rtl/serial_flash_command_sequencer_unit.sv
`timescale 1ns / 1ps
// A word is pushed into the command queue when accepted; its results then pass through the output register.
// Throughput: a word is accepted every cycle while the two-entry command queue has room;
// the output side then delivers one result per cycle while the receiver is ready, and a word
// causes one to seven results.
// Reset is synchronous and active low: state goes idle and invert_data returns to one.

module serial_flash_command_sequencer_unit
    import sfcs_pkg::*;
#(
    parameter int PAGE_BYTES   = PAGE_BYTES_DEF,
    parameter int SECTOR_BYTES = SECTOR_BYTES_DEF,
    parameter int ADDR_BITS    = ADDR_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // address[23:0], length[48:24], data[56:49], zeros
    input  logic [2:0]  s_axis_tuser,   // operation[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // value[7:0], frame_end[8], zeros
    output logic [2:0]  m_axis_tuser,   // kind[2:0]
    output logic        m_axis_tlast
);

    logic   take;
    logic   q_full;
    logic   q_valid;
    logic   q_pop;
    t_batch batch;
    t_batch head;
    t_res   res;

    assign s_axis_tready = !q_full;
    assign take          = s_axis_tvalid && !q_full;

    // Front: classifies each word and builds its result list.
    sfcs_front #(
        .PAGE_BYTES   (PAGE_BYTES),
        .SECTOR_BYTES (SECTOR_BYTES),
        .ADDR_BITS    (ADDR_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_take      (take),
        .i_op        (s_axis_tuser),
        .i_addr      (s_axis_tdata[23:0]),
        .i_len       (s_axis_tdata[48:24]),
        .i_data      (s_axis_tdata[56:49]),
        .o_batch     (batch)
    );

    // Queue between front and back.
    sfcs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (take),
        .i_data  (batch),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_head  (head)
    );

    // Back: plays out results one word at a time.
    sfcs_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (q_valid),
        .i_head       (head),
        .o_pop        (q_pop),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_res        (res),
        .o_last       (m_axis_tlast)
    );

    assign m_axis_tdata = {7'b0, res.fe, res.value};
    assign m_axis_tuser = res.kind;

endmodule

// File: rtl/sfcs_checker.sv
`timescale 1ns / 1ps

module sfcs_checker
    import sfcs_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    // A stalled result word holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("stalled result word changed");

    // Nothing is offered right after reset.
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // Only defined result kinds appear.
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tuser <= K_ERR)
        else $error("undefined result kind");

    // Only transmit and host data carry a value.
    a_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != K_TX && m_axis_tuser != K_HOST
            |-> m_axis_tdata[7:0] == 8'h00)
        else $error("nonzero value on a status result");

    // Chip select is released only after a bus byte.
    a_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[8] |-> m_axis_tuser == K_TX || m_axis_tuser == K_RX)
        else $error("frame end on a non-bus result");

endmodule

bind serial_flash_command_sequencer_unit sfcs_checker u_sfcs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

// File: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import sfcs_pkg::*;

    localparam int CYCLE_LIMIT    = 400000;
    localparam int MISMATCH_SHOWN = 10;

    // One expected SPI action or host result.
    typedef struct {
        t_kind      kind;
        logic [7:0] value;
        logic       fe;
        logic       last;
    } t_spi_action;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;   // address[23:0], length[48:24], data[56:49], zeros
    logic [2:0]  s_axis_tuser;   // operation[2:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;   // value[7:0], frame_end[8], zeros
    logic [2:0]  m_axis_tuser;   // kind[2:0]
    logic        m_axis_tlast;

    // Shadow of the sequencer state, updated as each word is accepted.
    logic        fl_inv;
    t_phase      fl_phase;
    t_req        fl_req;
    logic [23:0] fl_addr;
    logic [24:0] fl_left;

    t_spi_action spi_actions_due[$];
    t_spi_action word_actions[$];

    int send_idle;
    int recv_idle;
    int hold_off_cycles;
    int words_sent;
    int mismatch_count;
    int cycle_count;

    serial_flash_command_sequencer_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Prediction of the SPI actions caused by each accepted word.
    // ------------------------------------------------------------------

    function automatic void emit(t_kind kind, logic [7:0] value, logic fe);
        t_spi_action a;
        a.kind  = kind;
        a.value = value;
        a.fe    = fe;
        a.last  = 1'b0;
        word_actions.push_back(a);
    endfunction

    // A status poll is RDSR followed by one clocked-in byte.
    function automatic void emit_status_poll();
        emit(K_TX, CMD_RDSR, 1'b0);
        emit(K_RX, 8'h00, 1'b1);
        fl_phase = PH_POLL;
    endfunction

    // Three address bytes, most significant first.
    function automatic void emit_flash_address(logic fe);
        emit(K_TX, fl_addr[23:16], 1'b0);
        emit(K_TX, fl_addr[15:8], 1'b0);
        emit(K_TX, fl_addr[7:0], fe);
    endfunction

    function automatic void close_request();
        emit(K_DONE, 8'h00, 1'b0);
        fl_phase = PH_IDLE;
        fl_req   = REQ_NONE;
    endfunction

    // The flash reported ready: issue the command that was waiting for it.
    function automatic void start_flash_command();
        case (fl_req)
            REQ_READ: begin
                emit(K_TX, CMD_READ, 1'b0);
                if (fl_left == 0) begin
                    emit_flash_address(1'b1);
                    close_request();
                end else begin
                    emit_flash_address(1'b0);
                    emit(K_RX, 8'h00, fl_left == 1);
                    fl_phase = PH_READ;
                end
            end
            REQ_WRITE: begin
                emit(K_TX, CMD_WREN, 1'b1);
                emit(K_TX, CMD_PP, 1'b0);
                emit_flash_address(1'b0);
                fl_phase = PH_WRITE;
            end
            REQ_ERASE: begin
                emit(K_TX, CMD_WREN, 1'b1);
                emit(K_TX, CMD_SE, 1'b0);
                emit_flash_address(1'b1);
                fl_addr = fl_addr + 24'(SECTOR_BYTES_DEF);
                fl_left = fl_left - 25'(SECTOR_BYTES_DEF);
                if (fl_left == 0) begin
                    close_request();
                end else begin
                    emit_status_poll();
                end
            end
            default: begin
                close_request();
            end
        endcase
    endfunction

    function automatic void predict_flash_word(logic [2:0] op, logic [23:0] addr,
                                               logic [24:0] len, logic [7:0] data);
        logic       bad;
        logic       fe;
        logic [7:0] mask;
        bad  = 1'b0;
        mask = fl_inv ? INV_MASK : 8'h00;
        word_actions.delete();
        case (op)
            OP_READ, OP_WRITE, OP_ERASE: begin
                if (fl_phase != PH_IDLE) begin
                    bad = 1'b1;
                end else if (op == OP_ERASE && ((addr % SECTOR_BYTES_DEF) != 0 ||
                                                (len % SECTOR_BYTES_DEF) != 0)) begin
                    emit(K_REJ, 8'h00, 1'b0);
                end else if (op != OP_READ && len == 0) begin
                    emit(K_DONE, 8'h00, 1'b0);
                end else begin
                    fl_req  = (op == OP_READ) ? REQ_READ :
                              (op == OP_WRITE) ? REQ_WRITE : REQ_ERASE;
                    fl_addr = addr;
                    fl_left = len;
                    emit_status_poll();
                end
            end
            OP_WDATA: begin
                if (fl_phase != PH_WRITE || fl_left == 0) begin
                    bad = 1'b1;
                end else begin
                    fl_addr = fl_addr + 24'd1;
                    fl_left = fl_left - 25'd1;
                    fe = (fl_left == 0) || ((fl_addr % PAGE_BYTES_DEF) == 0);
                    emit(K_TX, data ^ mask, fe);
                    if (fl_left == 0) begin
                        close_request();
                    end else if (fe) begin
                        emit_status_poll();
                    end
                end
            end
            OP_STATUS: begin
                if (fl_phase != PH_POLL) begin
                    bad = 1'b1;
                end else if ((data & WIP_MASK) != 0) begin
                    emit_status_poll();
                end else begin
                    start_flash_command();
                end
            end
            OP_RDATA: begin
                if (fl_phase != PH_READ || fl_left == 0) begin
                    bad = 1'b1;
                end else begin
                    emit(K_HOST, data ^ mask, 1'b0);
                    fl_addr = fl_addr + 24'd1;
                    fl_left = fl_left - 25'd1;
                    if (fl_left == 0) begin
                        close_request();
                    end else begin
                        emit(K_RX, 8'h00, fl_left == 1);
                    end
                end
            end
            default: begin
                bad = 1'b1;
            end
        endcase
        if (bad) begin
            emit(K_ERR, 8'h00, 1'b0);
        end
        word_actions[word_actions.size() - 1].last = 1'b1;
        foreach (word_actions[i]) begin
            spi_actions_due.push_back(word_actions[i]);
        end
    endfunction

    // ------------------------------------------------------------------
    // Output side: ready pattern and result checking.
    // ------------------------------------------------------------------

    // The receiver stalls at random, or holds off entirely while a hold-off is running.
    always @(negedge i_clk) begin
        if (hold_off_cycles > 0) begin
            hold_off_cycles = hold_off_cycles - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    task automatic log_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MISMATCH_SHOWN) begin
            $display("%s", msg);
        end
    endtask

    // Every accepted result word is compared with the oldest expectation.
    always @(posedge i_clk) begin
        t_spi_action due;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (spi_actions_due.size() == 0) begin
                log_mismatch($sformatf("unexpected result: kind %0d value %02h fe %0d last %0d",
                                       m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[8],
                                       m_axis_tlast));
            end else begin
                due = spi_actions_due.pop_front();
                if (m_axis_tuser != due.kind || m_axis_tdata[7:0] != due.value ||
                    m_axis_tdata[8] != due.fe || m_axis_tlast != due.last) begin
                    log_mismatch({
                        $sformatf("mismatch: expected kind %0d value %02h fe %0d last %0d, ",
                                  due.kind, due.value, due.fe, due.last),
                        $sformatf("got kind %0d value %02h fe %0d last %0d",
                                  m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[8],
                                  m_axis_tlast)});
                end
            end
        end
    end

    // Hard stop in case the block hangs.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Input side.
    // ------------------------------------------------------------------

    // Offers one word, with random gaps first, and records its results once accepted.
    task automatic send_word(input logic [2:0] op, input logic [23:0] addr,
                             input logic [24:0] len, input logic [7:0] data);
        while ($urandom_range(0, 99) < send_idle) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tuser  = op;
        s_axis_tdata  = {7'd0, data, len, addr};
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_flash_word(op, addr, len, data);
        words_sent++;
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
    endtask

    // Waits until every expected result has come, then lets the block settle.
    task automatic wait_drain();
        while (spi_actions_due.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    task automatic set_invert(input logic value);
        wait_drain();
        i_cfg_we    = 1'b1;
        i_cfg_wdata = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        fl_inv   = value;
    endtask

    function automatic logic [24:0] rand_len25();
        return 25'($urandom);
    endfunction

    // Addresses lean toward page ends and the top of the address space.
    function automatic logic [23:0] pick_address();
        logic [23:0] a;
        a = 24'($urandom);
        case ($urandom_range(0, 3))
            0: a[23:8] = 16'hFFFF;
            1: a[7:0]  = 8'(8'hF0 + $urandom_range(0, 15));
            default: ;
        endcase
        return a;
    endfunction

    function automatic logic [24:0] pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return 25'($urandom_range(0, 6));
        end else if (r < 95) begin
            return 25'($urandom_range(7, 40));
        end
        return 25'($urandom_range(41, 300));
    endfunction

    // Any word with random fields; while idle, no read or write request is sent.
    task automatic send_noise(input logic busy);
        logic [2:0] op;
        op = busy ? 3'($urandom_range(0, 7)) : 3'($urandom_range(2, 7));
        send_word(op, 24'($urandom), rand_len25(), 8'($urandom));
    endtask

    // Plays the flash side of the current phase.
    task automatic answer_flash();
        logic [7:0] b;
        b = 8'($urandom);
        case (fl_phase)
            PH_POLL: begin
                if ($urandom_range(0, 99) < 70) begin
                    b = b & ~WIP_MASK;
                end
                send_word(OP_STATUS, 24'($urandom), rand_len25(), b);
            end
            PH_WRITE: send_word(OP_WDATA, 24'($urandom), rand_len25(), b);
            PH_READ:  send_word(OP_RDATA, 24'($urandom), rand_len25(), b);
            default:  send_noise(1'b0);
        endcase
    endtask

    task automatic start_erase();
        logic [23:0] a;
        logic [24:0] n;
        int          r;
        a = 24'($urandom_range(0, 255)) << 16;
        n = 25'($urandom_range(0, 3)) << 16;
        r = $urandom_range(0, 99);
        if (r < 10) begin
            n = n + 25'($urandom_range(1, 65535));
        end else if (r < 20) begin
            a = a | 24'($urandom_range(1, 65535));
        end
        send_word(OP_ERASE, a, n, 8'($urandom));
    endtask

    // Mostly complete request sequences with random content, some noise mixed in.
    task automatic run_random_traffic(input int words);
        int stop_at;
        int pick;
        stop_at = words_sent + words;
        while (words_sent < stop_at || fl_phase != PH_IDLE) begin
            pick = $urandom_range(0, 99);
            if (fl_phase != PH_IDLE) begin
                if (pick < 5) begin
                    send_noise(1'b1);
                end else begin
                    answer_flash();
                end
            end else if (pick < 8) begin
                send_noise(1'b0);
            end else if (pick < 45) begin
                send_word(OP_READ, pick_address(), pick_length(), 8'($urandom));
            end else if (pick < 82) begin
                send_word(OP_WRITE, pick_address(), pick_length(), 8'($urandom));
            end else begin
                start_erase();
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Words that are wrong while idle, empty requests and misaligned erases.
    task automatic test_idle_errors();
        send_word(OP_WDATA, 24'h000000, 25'h0000000, 8'h00);
        send_word(OP_STATUS, 24'hFFFFFF, 25'h1FFFFFF, 8'hFF);
        send_word(OP_RDATA, 24'h000000, 25'h0000000, 8'h00);
        send_word(3'd6, 24'hFFFFFF, 25'h1FFFFFF, 8'hFF);
        send_word(3'd7, 24'h000000, 25'h0000000, 8'h00);
        send_word(OP_WRITE, 24'hFFFFFF, 25'h0000000, 8'hFF);
        send_word(OP_ERASE, 24'hFF0000, 25'h0000000, 8'h00);
        send_word(OP_ERASE, 24'h000001, 25'h0000000, 8'h00);
        send_word(OP_ERASE, 24'h000000, 25'h1FFFFFF, 8'h00);
    endtask

    // An empty read still sends the command and address, after a busy poll.
    task automatic test_zero_length_read();
        send_word(OP_READ, 24'hFFFFFF, 25'h0000000, 8'h00);
        send_word(OP_STATUS, 24'h000000, 25'h0000000, 8'hFF);
        send_word(OP_STATUS, 24'h000000, 25'h0000000, 8'hFE);
    endtask

    // A write that crosses a page end, with a request refused while busy.
    task automatic test_page_split_write();
        send_word(OP_WRITE, 24'h0000FE, 25'd3, 8'h00);
        send_word(OP_STATUS, 24'h000000, 25'h0000000, 8'h00);
        send_word(OP_WDATA, 24'h000000, 25'h0000000, 8'h00);
        send_word(OP_READ, 24'h123456, 25'd1, 8'h00);
        send_word(OP_WDATA, 24'h000000, 25'h0000000, 8'hFF);
        send_word(OP_STATUS, 24'h000000, 25'h0000000, 8'h00);
        send_word(OP_WDATA, 24'h000000, 25'h0000000, 8'hA5);
    endtask

    // A short read, then a two-sector erase that wraps past the top address.
    task automatic test_read_then_erase_wrap();
        send_word(OP_READ, 24'h123456, 25'd2, 8'h00);
        send_word(OP_STATUS, 24'h000000, 25'h0000000, 8'h00);
        send_word(OP_RDATA, 24'h000000, 25'h0000000, 8'h00);
        send_word(OP_RDATA, 24'h000000, 25'h0000000, 8'hFF);
        send_word(OP_ERASE, 24'hFF0000, 25'h0020000, 8'h00);
        send_word(OP_STATUS, 24'h000000, 25'h0000000, 8'h00);
        send_word(OP_STATUS, 24'h000000, 25'h0000000, 8'h00);
    endtask

    // The receiver holds off while a page-crossing write keeps coming, then the sender waits.
    task automatic test_backpressure();
        hold_off_cycles = 200;
        send_word(OP_WRITE, 24'h0000F8, 25'd12, 8'h00);
        send_word(OP_STATUS, 24'h000000, 25'h0000000, 8'h00);
        repeat (8) send_word(OP_WDATA, 24'h000000, 25'h0000000, 8'($urandom));
        send_word(OP_STATUS, 24'h000000, 25'h0000000, 8'h00);
        repeat (4) send_word(OP_WDATA, 24'h000000, 25'h0000000, 8'($urandom));
        wait_drain();
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_wdata     = 1'b0;
        s_axis_tvalid   = 1'b0;
        s_axis_tdata    = '0;
        s_axis_tuser    = '0;
        send_idle       = 31;
        recv_idle       = 63;
        hold_off_cycles = 0;
        words_sent      = 0;
        mismatch_count  = 0;
        cycle_count     = 0;
        fl_inv          = 1'b1;
        fl_phase        = PH_IDLE;
        fl_req          = REQ_NONE;
        fl_addr         = '0;
        fl_left         = '0;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        set_invert(1'b1);
        test_idle_errors();
        test_zero_length_read();
        test_page_split_write();
        test_read_then_erase_wrap();
        run_random_traffic(125);
        test_backpressure();

        set_invert(1'b0);
        send_idle = 63;
        recv_idle = 31;
        run_random_traffic(125);

        set_invert(1'b1);
        send_idle = 0;
        recv_idle = 0;
        run_random_traffic(125);

        wait_drain();
        repeat (10) @(negedge i_clk);
        if (mismatch_count == 0 && spi_actions_due.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// File: serial_flash_command_sequencer_unit.f
rtl/sfcs_pkg.sv
rtl/sfcs_front.sv
rtl/sfcs_queue.sv
rtl/sfcs_back.sv
rtl/serial_flash_command_sequencer_unit.sv
rtl/sfcs_checker.sv
sim/testbench.sv
